>>> hdl/assert_macros.svh
// assertion macros used by the table rtl
// no dependencies; included by modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DMT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("dmt assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DMT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("dmt assertion failed");

`endif

>>> hdl/dmt_pkg.sv
// types, constants and state codes of the direct-mapped depth-replace table
// no dependencies
package dmt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 1024;
	localparam int unsigned KEY_W             = 64;
	localparam int unsigned DEPTH_W           = 16;
	localparam int unsigned FLAG_W            = 2;
	localparam int unsigned MOVE_W            = 16;
	localparam int unsigned SCORE_W           = 32;

	// key bits folded into the slot remainder per cycle
	localparam int unsigned MOD_BITS  = 8;
	localparam int unsigned MOD_STEPS = KEY_W / MOD_BITS;
	localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

	typedef enum logic {
		KIND_LOOKUP = 1'b0,
		KIND_STORE  = 1'b1
	} dmt_kind_t;

	typedef struct packed {
		dmt_kind_t                  kind;
		logic [KEY_W-1:0]           key;
		logic [DEPTH_W-1:0]         depth;
		logic [FLAG_W-1:0]          bound_flag;
		logic [MOVE_W-1:0]          best_move;
		logic signed [SCORE_W-1:0]  best_score;
	} dmt_req_t;

	typedef struct packed {
		logic                       hit;
		logic                       written;
		logic [DEPTH_W-1:0]         found_depth;
		logic [FLAG_W-1:0]          found_flag;
		logic [MOVE_W-1:0]          found_move;
		logic signed [SCORE_W-1:0]  found_score;
	} dmt_rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]           key;
		logic [DEPTH_W-1:0]         depth;
		logic [FLAG_W-1:0]          flag;
		logic [MOVE_W-1:0]          move;
		logic signed [SCORE_W-1:0]  score;
	} dmt_entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_CHECK
	} dmt_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic mod_step;
		logic rd_en;
		logic finish;
		logic clr_en;
	} dmt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_mod;
		logic mod_done;
		logic clr_last;
		logic out_free;
	} dmt_sts_t;

endpackage

>>> hdl/dmt_stream_if.sv
// valid/ready channel carrying one payload struct
// payload types come from dmt_pkg
interface dmt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/dmt_ctrl.sv
// sequencer for clear pass, slot index, table read and result write-back
// depends on dmt_pkg and assert_macros.svh
`include "assert_macros.svh"

module dmt_ctrl
	import dmt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dmt_sts_t sts,
	output dmt_cmd_t cmd
);

	dmt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = sts.needs_mod ? ST_MOD : ST_READ;
			end
			ST_MOD: begin
				if (sts.mod_done) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_CHECK: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`DMT_ASSERT_IMP(a_finish_needs_room, clk, arst_n, cmd.finish, sts.out_free)
	`DMT_ASSERT_NXT(a_clear_ends_idle, clk, arst_n, state_q == ST_CLEAR && sts.clr_last, state_q == ST_IDLE)
	`DMT_ASSERT_NXT(a_accept_starts_work, clk, arst_n, cmd.accept, state_q == ST_MOD || state_q == ST_READ)

endmodule

>>> hdl/dmt_datapath.sv
// request registers, slot remainder unit, table memories and result register
// depends on dmt_pkg
module dmt_datapath
	import dmt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dmt_req_t req_data,
	input  dmt_cmd_t cmd,
	output dmt_sts_t sts,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output dmt_rsp_t rsp_data
);

	localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam bit          IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
	localparam logic [IDX_W:0]   N_EXT    = (IDX_W+1)'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [MOD_CNT_W-1:0] LAST_STEP = MOD_CNT_W'(MOD_STEPS - 1);

	dmt_req_t             req_q;
	logic [KEY_W-1:0]     kshift_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     idx_step;
	logic [IDX_W-1:0]     clr_q;

	dmt_entry_t mem [TABLE_ENTRIES];
	logic       vmem [TABLE_ENTRIES];
	dmt_entry_t rd_entry_q;
	logic       rd_valid_q;

	logic       hit;
	logic       do_write;
	logic       out_valid_q;
	dmt_rsp_t   rsp_q;

	// fold the next key bits into the remainder, msb first
	always_comb begin
		logic [IDX_W:0]   t;
		logic [IDX_W-1:0] r;
		r = idx_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			t = {r, kshift_q[KEY_W-1-i]};
			if (t >= N_EXT) t = t - N_EXT;
			r = t[IDX_W-1:0];
		end
		idx_step = r;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q    <= req_data;
			kshift_q <= req_data.key;
			idx_q    <= IS_POW2 ? req_data.key[IDX_W-1:0] : '0;
		end else if (cmd.mod_step) begin
			kshift_q <= kshift_q << MOD_BITS;
			idx_q    <= idx_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q <= '0;
			clr_q     <= '0;
		end else begin
			if (cmd.accept) mod_cnt_q <= '0;
			else if (cmd.mod_step) mod_cnt_q <= mod_cnt_q + 1'b1;
			if (cmd.clr_en) clr_q <= clr_q + 1'b1;
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		if (cmd.finish && do_write) begin
			mem[idx_q] <= '{key: req_q.key, depth: req_q.depth, flag: req_q.bound_flag,
			                move: req_q.best_move, score: req_q.best_score};
		end
		if (cmd.rd_en) rd_entry_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) vmem[clr_q] <= 1'b0;
		else if (cmd.finish && do_write) vmem[idx_q] <= 1'b1;
		if (cmd.rd_en) rd_valid_q <= vmem[idx_q];
	end

	assign hit      = (req_q.kind == KIND_LOOKUP) && rd_valid_q && (rd_entry_q.key == req_q.key);
	assign do_write = (req_q.kind == KIND_STORE) &&
	                  (!rd_valid_q || (req_q.depth > rd_entry_q.depth));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.hit         <= hit;
			rsp_q.written     <= do_write;
			rsp_q.found_depth <= hit ? rd_entry_q.depth : '0;
			rsp_q.found_flag  <= hit ? rd_entry_q.flag  : '0;
			rsp_q.found_move  <= hit ? rd_entry_q.move  : '0;
			rsp_q.found_score <= hit ? rd_entry_q.score : '0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = rsp_q;

	assign sts.needs_mod = !IS_POW2;
	assign sts.mod_done  = (mod_cnt_q == LAST_STEP);
	assign sts.clr_last  = (clr_q == LAST_IDX);
	assign sts.out_free  = !out_valid_q || rsp_ready;

endmodule

>>> hdl/direct_mapped_table_depth_replace.sv
// top level of the direct-mapped table with depth-preferred replacement
// depends on dmt_pkg, dmt_stream_if, dmt_ctrl and dmt_datapath
//
// channel  | dir | payload   | contents
// ---------+-----+-----------+-------------------------------------------------
// request  | in  | dmt_req_t | kind, key, depth, bound_flag, best_move, score
// result   | out | dmt_rsp_t | hit, written, found depth/flag/move/score
//
// for a power-of-two TABLE_ENTRIES a request steps through accept, table read, and compare and
// write-back, the result turning valid after the compare and write-back step; otherwise 8 key
// bits are first folded into the slot index per cycle
// after reset the valid marks are cleared one slot a cycle through all TABLE_ENTRIES slots, ready low
// a finished result waits in the result register while the next request is taken;
// write-back stalls while that register is still full and result.ready is low
module direct_mapped_table_depth_replace
	import dmt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dmt_stream_if.sink   request,
	dmt_stream_if.source result
);

	// command and status between sequencer and datapath
	dmt_cmd_t cmd;
	dmt_sts_t sts;

	// sequencer: clear pass, index, read, check and write-back
	dmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: slot index, key/data memory, valid marks, result register
	dmt_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (request.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (result.valid),
		.rsp_ready (result.ready),
		.rsp_data  (result.data)
	);

endmodule
